@@ hdl/travel_matte_pixel_blend_core_defines.svh @@
// Assertion macros shared by the matte blend RTL.
// Needs a clock port named clock and an active-high reset named reset in scope.
`ifndef TRAVEL_MATTE_PIXEL_BLEND_CORE_DEFINES_SVH
`define TRAVEL_MATTE_PIXEL_BLEND_CORE_DEFINES_SVH

// checked outside reset
`define TMPB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define TMPB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/tmpb_pkg.sv @@
// Shared types, constants and divide-by-constant helpers for the matte blend core.
// No dependencies.
package tmpb_pkg;

   typedef struct packed {
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
      logic [7:0] luma;
   } pix_type;

   typedef struct packed {
      logic              source;
      logic [10:0]       gain;
      logic signed [8:0] bias;
      logic [7:0]        soften;
      logic [9:0]        drive;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_SOURCE = 3'd0,
      CSR_GAIN   = 3'd1,
      CSR_BIAS   = 3'd2,
      CSR_SOFTEN = 3'd3,
      CSR_DRIVE  = 3'd4
   } csr_idx_type;

   localparam logic [10:0] GAIN_MAX    = 11'd2000;
   localparam logic [10:0] GAIN_RESET  = 11'd1000;
   localparam logic [9:0]  DRIVE_MAX   = 10'd1000;
   localparam logic [8:0]  BIAS_MIN    = 9'h101;   // -255
   localparam logic [8:0]  BIAS_ILLEGAL = 9'h100;  // -256
   localparam logic [7:0]  FULL        = 8'd255;
   localparam logic [7:0]  MID         = 8'd128;
   localparam logic [8:0]  ROUND_1000  = 9'd500;
   localparam logic [6:0]  ROUND_255   = 7'd127;

   // floor(x/1000) exact for x < 2^19: multiplier error 88 * 2^19 < 2^29
   localparam logic [19:0] DIV1000_MUL = 20'd536871;
   // floor(x/255) exact for x < 2^16: multiplier error 254 * 2^16 < 2^24
   localparam logic [16:0] DIV255_MUL  = 17'd65794;

   function automatic logic [9:0] div1000(input logic [18:0] x);
      logic [38:0] p;
      p = {20'd0, x} * {19'd0, DIV1000_MUL};
      return p[38:29];
   endfunction

   function automatic logic [8:0] div255(input logic [15:0] x);
      logic [32:0] p;
      p = {17'd0, x} * {16'd0, DIV255_MUL};
      return p[32:24];
   endfunction

endpackage

@@ hdl/tmpb_matte.sv @@
// Seven-stage matte shaping pipeline: gain, bias and clamp, soften, drive.
// Carries both pixels alongside. Uses tmpb_pkg and the assertion macro header.
`include "travel_matte_pixel_blend_core_defines.svh"

module tmpb_matte
   import tmpb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  pix_type    in_pix_a,
   input  pix_type    in_pix_b,
   input  logic [7:0] in_alpha_a,
   input  logic [7:0] in_alpha_b,
   output logic       out_valid,
   input  logic       out_ready,
   output pix_type    out_pix_a,
   output pix_type    out_pix_b,
   output logic [7:0] out_alpha
);

   localparam int NS = 7;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;
   pix_type       pa_ff [NS];
   pix_type       pb_ff [NS];

   logic [18:0] prod_ff, prod_in;
   logic [8:0]  quo_ff, quo_in;
   logic [7:0]  bv_ff, bv_in;
   logic [15:0] soft_ff, soft_in;
   logic [7:0]  sv_ff, sv_in;
   logic [17:0] drv_ff, drv_in;
   logic [7:0]  dv_ff;
   logic [7:0]  alpha_ff, alpha_in;

   logic [7:0]         alpha_sel;
   logic [9:0]         quo_full;
   logic signed [10:0] biased;
   logic [8:0]         soft_quo;
   logic [9:0]         drv_quo;
   logic [8:0]         drv_sum;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // stage 0: scaled matte plus rounding
   assign alpha_sel = cfg.source ? in_alpha_b : in_alpha_a;
   assign prod_in   = {11'd0, alpha_sel} * {8'd0, cfg.gain} + {10'd0, ROUND_1000};

   // stage 1: divide by 1000
   assign quo_full = div1000(prod_ff);
   assign quo_in   = quo_full[8:0];

   // stage 2: bias and clamp
   assign biased = $signed({2'b00, quo_ff}) + $signed({{2{cfg.bias[8]}}, cfg.bias});
   always_comb begin
      priority if (biased[10]) begin
         bv_in = 8'd0;
      end else if (biased > 11'sd255) begin
         bv_in = FULL;
      end else begin
         bv_in = biased[7:0];
      end
   end

   // stage 3: soften numerator; strength zero yields the identity
   assign soft_in = {8'd0, bv_ff} * {8'd0, 8'(FULL - cfg.soften)}
                  + {1'b0, cfg.soften, 7'd0} + {9'd0, ROUND_255};

   // stage 4: divide by 255
   assign soft_quo = div255(soft_ff);
   assign sv_in    = soft_quo[7:0];

   // stage 5: drive numerator; drive zero yields the identity
   assign drv_in = {10'd0, 8'(FULL - sv_ff)} * {8'd0, cfg.drive} + {9'd0, ROUND_1000};

   // stage 6: divide by 1000, add, saturate
   assign drv_quo = div1000({1'b0, drv_ff});
   assign drv_sum = {1'b0, dv_ff} + drv_quo[8:0];
   assign alpha_in = (drv_sum > 9'd255) ? FULL : drv_sum[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pa_ff[0] <= in_pix_a;
         pb_ff[0] <= in_pix_b;
         prod_ff  <= prod_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (rdy[k]) begin
            pa_ff[k] <= pa_ff[k-1];
            pb_ff[k] <= pb_ff[k-1];
         end
      end
      if (rdy[1]) quo_ff   <= quo_in;
      if (rdy[2]) bv_ff    <= bv_in;
      if (rdy[3]) soft_ff  <= soft_in;
      if (rdy[4]) sv_ff    <= sv_in;
      if (rdy[5]) begin
         drv_ff <= drv_in;
         dv_ff  <= sv_ff;
      end
      if (rdy[6]) alpha_ff <= alpha_in;
   end

   assign out_valid = vld_ff[NS-1];
   assign out_pix_a = pa_ff[NS-1];
   assign out_pix_b = pb_ff[NS-1];
   assign out_alpha = alpha_ff;

   `TMPB_ASSERT(a_soft_range, vld_ff[3] |-> soft_quo <= 9'd255, "soften quotient above 255")
   `TMPB_ASSERT(a_drive_range, vld_ff[5] |-> drv_sum <= 9'd255, "driven matte above 255")
   `TMPB_ASSERT(a_stall_hold,
      vld_ff[NS-1] && !out_ready |=> vld_ff[NS-1] && $stable(alpha_ff),
      "stalled matte changed")
   `TMPB_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> vld_ff == '0, "valid after reset")

endmodule

@@ hdl/tmpb_blend.sv @@
// Two-stage per-component blend of pixel A toward pixel B by the shaped matte.
// Uses tmpb_pkg and the assertion macro header.
`include "travel_matte_pixel_blend_core_defines.svh"

module tmpb_blend
   import tmpb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  pix_type    in_pix_a,
   input  pix_type    in_pix_b,
   input  logic [7:0] in_alpha,
   output logic       out_valid,
   input  logic       out_ready,
   output pix_type    out_pix
);

   logic [1:0]  vld_ff;
   logic [2:0]  rdy;
   logic [15:0] sum_ff [3];
   logic [15:0] sum_in [3];
   logic [8:0]  quo    [3];
   pix_type     pix_ff;

   function automatic logic [15:0] mix_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] al);
      return {8'd0, a} * {8'd0, 8'(FULL - al)} + {8'd0, b} * {8'd0, al}
           + {9'd0, ROUND_255};
   endfunction

   assign rdy[2]   = out_ready;
   assign rdy[1]   = !vld_ff[1] || rdy[2];
   assign rdy[0]   = !vld_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   // alpha 0 and 255 reduce exactly to A and B through this formula
   assign sum_in[0] = mix_sum(in_pix_a.luma,     in_pix_b.luma,     in_alpha);
   assign sum_in[1] = mix_sum(in_pix_a.chroma_u, in_pix_b.chroma_u, in_alpha);
   assign sum_in[2] = mix_sum(in_pix_a.chroma_v, in_pix_b.chroma_v, in_alpha);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         quo[k] = div255(sum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_in[k];
         end
      end
      if (rdy[1]) begin
         pix_ff.luma     <= quo[0][7:0];
         pix_ff.chroma_u <= quo[1][7:0];
         pix_ff.chroma_v <= quo[2][7:0];
      end
   end

   assign out_valid = vld_ff[1];
   assign out_pix   = pix_ff;

   `TMPB_ASSERT(a_quo_range,
      vld_ff[0] |-> quo[0] <= 9'd255 && quo[1] <= 9'd255 && quo[2] <= 9'd255,
      "blend quotient above 255")
   `TMPB_ASSERT(a_sum_hold, vld_ff[0] && !rdy[1] |=> vld_ff[0] && $stable(sum_ff[0]),
      "stalled blend sum changed")
   `TMPB_ASSERT(a_no_drop, vld_ff[1] && !out_ready |=> vld_ff[1], "stalled result dropped")

endmodule

@@ hdl/travel_matte_pixel_blend_core.sv @@
// Travel matte pixel blend: top level with config registers and stream ports.
// Uses tmpb_pkg, tmpb_matte and tmpb_blend.
//
// Usage:
//   req_ carries one pixel pair per beat: both YUV pixels and both alpha samples.
//   rsp_ returns one blended YUV pixel per request beat, in order.
//   csr_ writes a register when csr_we is high; write only while the pipe is empty.
// An accepted request beat runs through the matte stages, then the blend stages.
// Throughput: one beat per cycle unless stalled, set by the nine-stage pipeline (seven
//   matte stages, two blend stages), every multiply followed by a register.
// Stall: each stage holds while full and blocked downstream; req_tready stays
//   high while any stage has room, so bubbles are squeezed out.
// Reset: pipeline empties; matte taken from frame B, gain 1000, bias, soften
//   and drive zero.
module travel_matte_pixel_blend_core
   import tmpb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // a_luma, a_chroma_u, a_chroma_v, b_luma, b_chroma_u, b_chroma_v, alpha_a, alpha_b
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_luma, out_chroma_u, out_chroma_v
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [10:0] csr_wdata
);

   cfg_type    cfg_ff;
   pix_type    pix_a, pix_b, mid_pa, mid_pb, out_pix;
   logic [7:0] mid_alpha;
   logic       mid_valid, mid_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source <= 1'b1;
         cfg_ff.gain   <= GAIN_RESET;
         cfg_ff.bias   <= '0;
         cfg_ff.soften <= '0;
         cfg_ff.drive  <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_SOURCE: cfg_ff.source <= csr_wdata[0];
            CSR_GAIN:   cfg_ff.gain   <= (csr_wdata > GAIN_MAX) ? GAIN_MAX : csr_wdata;
            CSR_BIAS:   cfg_ff.bias   <= (csr_wdata[8:0] == BIAS_ILLEGAL) ?
                                         $signed(BIAS_MIN) : $signed(csr_wdata[8:0]);
            CSR_SOFTEN: cfg_ff.soften <= csr_wdata[7:0];
            CSR_DRIVE:  cfg_ff.drive  <= (csr_wdata[9:0] > DRIVE_MAX) ?
                                         DRIVE_MAX : csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   assign pix_a.luma     = req_tdata[7:0];
   assign pix_a.chroma_u = req_tdata[15:8];
   assign pix_a.chroma_v = req_tdata[23:16];
   assign pix_b.luma     = req_tdata[31:24];
   assign pix_b.chroma_u = req_tdata[39:32];
   assign pix_b.chroma_v = req_tdata[47:40];

   tmpb_matte u_matte (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pix_a   (pix_a),
      .in_pix_b   (pix_b),
      .in_alpha_a (req_tdata[55:48]),
      .in_alpha_b (req_tdata[63:56]),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_pix_a  (mid_pa),
      .out_pix_b  (mid_pb),
      .out_alpha  (mid_alpha)
   );

   tmpb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_pix_a  (mid_pa),
      .in_pix_b  (mid_pb),
      .in_alpha  (mid_alpha),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix)
   );

   assign rsp_tdata = {out_pix.chroma_v, out_pix.chroma_u, out_pix.luma};

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for travel_matte_pixel_blend_core: directed and random pixel pairs under
// a range of matte settings, each result checked against a blend predictor kept in the bench.
// Depends on tmpb_pkg and the core RTL; needs no files or arguments.
import tmpb_pkg::*;

typedef struct packed {
   logic [7:0] alpha_b;
   logic [7:0] alpha_a;
   pix_type    frame_b;
   pix_type    frame_a;
} pixel_pair_type;

class blend_scoreboard;
   cfg_type settings;
   pix_type expected_pixels[$];
   int      pixels_noted;
   int      pixels_checked;
   int      error_count;

   function new();
      settings = '{1'b1, GAIN_RESET, 9'd0, 8'd0, 10'd0};
   endfunction

   task report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("[%0t] mismatch: %s", $time, what);
   endtask

   function void write_register(input logic [2:0] idx, input logic [10:0] value);
      case (idx)
         CSR_SOURCE: settings.source = value[0];
         CSR_GAIN:   settings.gain   = value;
         CSR_BIAS:   settings.bias   = value[8:0];
         CSR_SOFTEN: settings.soften = value[7:0];
         CSR_DRIVE:  settings.drive  = value[9:0];
         default: ;
      endcase
   endfunction

   function int shaped_matte(input logic [7:0] raw);
      int gain_eff, bias_eff, soften_eff, drive_eff, level;
      gain_eff   = int'(settings.gain);
      bias_eff   = int'($signed(settings.bias));
      soften_eff = int'(settings.soften);
      drive_eff  = int'(settings.drive);
      if (gain_eff > GAIN_MAX) gain_eff = GAIN_MAX;
      if (bias_eff < -255) bias_eff = -255;
      if (drive_eff > DRIVE_MAX) drive_eff = DRIVE_MAX;
      level = int'(raw);
      level = (level * gain_eff + 500) / 1000 + bias_eff;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      if (soften_eff > 0) level = (level * (255 - soften_eff) + 128 * soften_eff + 127) / 255;
      if (drive_eff > 0) level = level + ((255 - level) * drive_eff + 500) / 1000;
      if (level > 255) level = 255;
      return level;
   endfunction

   function logic [7:0] blend_component(input logic [7:0] from_a, input logic [7:0] from_b,
                                        input int matte);
      int mixed;
      if (matte == 0) return from_a;
      if (matte >= 255) return from_b;
      mixed = (int'(from_a) * (255 - matte) + int'(from_b) * matte + 127) / 255;
      return mixed[7:0];
   endfunction

   function void note_request(input logic [63:0] beat);
      pixel_pair_type pair;
      pix_type        blended;
      int             matte;
      pair  = beat;
      matte = shaped_matte(settings.source ? pair.alpha_b : pair.alpha_a);
      blended.luma     = blend_component(pair.frame_a.luma, pair.frame_b.luma, matte);
      blended.chroma_u = blend_component(pair.frame_a.chroma_u, pair.frame_b.chroma_u, matte);
      blended.chroma_v = blend_component(pair.frame_a.chroma_v, pair.frame_b.chroma_v, matte);
      expected_pixels.push_back(blended);
      pixels_noted++;
   endfunction

   task check_pixel(input logic [23:0] beat);
      pix_type got, want;
      got = beat;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result beat %0d arrived with nothing pending", pixels_checked));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.luma !== want.luma)
         report_mismatch($sformatf("beat %0d luma %0d, want %0d",
                                   pixels_checked, got.luma, want.luma));
      if (got.chroma_u !== want.chroma_u)
         report_mismatch($sformatf("beat %0d chroma_u %0d, want %0d",
                                   pixels_checked, got.chroma_u, want.chroma_u));
      if (got.chroma_v !== want.chroma_v)
         report_mismatch($sformatf("beat %0d chroma_v %0d, want %0d",
                                   pixels_checked, got.chroma_v, want.chroma_v));
   endtask
endclass

module testbench;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         ITEMS_PER_PHASE = 78;
   localparam int         RANDOM_PHASES   = 5;
   localparam logic [2:0] CSR_SPARE_TOP   = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [10:0] csr_wdata  = '0;

   blend_scoreboard pixel_board = new();
   int beats_sent  = 0;
   int phases_run  = 0;
   int cycle_count = 0;
   bit steady_flow = 1'b0;

   travel_matte_pixel_blend_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) pixel_board.write_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) pixel_board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) pixel_board.check_pixel(rsp_tdata);
      end
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_tvalid);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, beats_sent - pixel_board.pixels_checked);
      $display("** travel_matte_pixel_blend_core: FAILED **");
      $finish;
   end

   function automatic logic [7:0] sample_level();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         3: return 8'd254;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_pair_type random_pair();
      pixel_pair_type pair;
      pair.frame_a.luma     = sample_level();
      pair.frame_a.chroma_u = sample_level();
      pair.frame_a.chroma_v = sample_level();
      pair.frame_b.luma     = sample_level();
      pair.frame_b.chroma_u = sample_level();
      pair.frame_b.chroma_v = sample_level();
      pair.alpha_a          = sample_level();
      pair.alpha_b          = sample_level();
      return pair;
   endfunction

   task automatic send_pixel(input pixel_pair_type pair);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      do begin
         @(posedge clock);
      end while (!req_tready);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pixel_board.pixels_checked < beats_sent);
   endtask

   task automatic put_register(input logic [2:0] idx, input logic [10:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // pipe must be empty before the registers change
   task automatic run_phase(input cfg_type c, input bit scrambled);
      logic [10:0] noise;
      drain_results();
      noise = scrambled ? 11'($urandom) : 11'd0;
      put_register(CSR_SOURCE, {noise[10:1], c.source});
      put_register(CSR_GAIN, c.gain);
      put_register(CSR_BIAS, {noise[10:9], c.bias});
      put_register(CSR_SOFTEN, {noise[10:8], c.soften});
      put_register(CSR_DRIVE, {noise[10], c.drive});
      put_register(3'($urandom_range(CSR_DRIVE + 1, CSR_SPARE_TOP)), 11'($urandom));
      csr_we <= 1'b0;
      phases_run++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         if (n % 20 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 2) == 0) drain_results();
         send_pixel(random_pair());
      end
   endtask

   initial begin
      cfg_type corner_settings[7];
      cfg_type setting;

      corner_settings = '{
         '{1'b0, 11'd0,      9'd0,         8'd0,   10'd0},
         '{1'b1, GAIN_MAX,   9'd0,         8'd0,   10'd0},
         '{1'b0, 11'd2047,   BIAS_ILLEGAL, 8'd0,   10'd0},
         '{1'b1, GAIN_RESET, 9'd255,       8'd0,   10'd0},
         '{1'b0, GAIN_RESET, BIAS_MIN,     FULL,   10'd0},
         '{1'b1, 11'd1500,   9'd0,         8'd0,   DRIVE_MAX},
         '{1'b0, 11'd700,    9'd30,        8'd100, 10'd1023}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: matte from frame B alpha, unity gain
      send_pixel({8'd0,   8'd0,   24'h000000, 24'h000000});
      send_pixel({8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF});
      send_pixel({8'd0,   8'd255, 24'hFFFFFF, 24'h000000});
      send_pixel({8'd255, 8'd0,   24'hFFFFFF, 24'h000000});
      send_pixel({8'd128, 8'd0,   24'hFFFFFF, 24'h000000});
      send_pixel({8'd1,   8'd0,   24'hFFFFFF, 24'h000000});
      send_pixel({8'd254, 8'd0,   24'hFFFFFF, 24'h000000});
      send_pixel({8'd2,   8'd0,   24'h000000, 24'hFFFFFF});
      send_pixel({8'd253, 8'd0,   24'h000000, 24'hFFFFFF});
      send_pixel({8'd127, 8'd200, 24'h000000, 24'hFFFFFF});
      send_pixel({8'hAA,  8'h55,  24'h55AA55, 24'hAA55AA});
      send_pixel({8'h55,  8'hAA,  24'hAA55AA, 24'h55AA55});
      send_pixel({8'd64,  8'd32,  24'hFEDCBA, 24'h123456});
      send_pixel({8'd200, 8'd17,  24'h102030, 24'h102030});
      send_pixel({8'd85,  8'd170, 24'h00FF80, 24'hFF0080});

      foreach (corner_settings[i]) run_phase(corner_settings[i], 1'b0);
      repeat (RANDOM_PHASES) begin
         setting.source = 1'($urandom);
         setting.gain   = 11'($urandom_range(0, 2047));
         setting.bias   = 9'($urandom);
         setting.soften = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
         setting.drive  = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom);
         run_phase(setting, 1'b1);
      end

      drain_results();
      repeat (12) @(posedge clock);
      if (pixel_board.expected_pixels.size() != 0)
         pixel_board.report_mismatch($sformatf("%0d expected results never arrived",
                                               pixel_board.expected_pixels.size()));

      $display("Covered %0d pixel-pair beats across reset values and %0d register settings.",
               beats_sent, phases_run);
      $display("%0d blended results compared, %0d mismatches.",
               pixel_board.pixels_checked, pixel_board.error_count);
      if (pixel_board.error_count == 0) begin
         $display("** travel_matte_pixel_blend_core: PASSED **");
      end else begin
         $display("** travel_matte_pixel_blend_core: FAILED **");
      end
      $finish;
   end
endmodule
